// ===== hdl/cna_pkg.sv =====
`default_nettype none
package cna_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QBITS = 33;

  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_CONJ = 3'd4;
  localparam logic [2:0] KIND_MOD  = 3'd5;
  localparam logic [2:0] KIND_EQ   = 3'd6;

  localparam logic [1:0] FAULT_OK   = 2'd0;
  localparam logic [1:0] FAULT_DIV0 = 2'd1;
  localparam logic [1:0] FAULT_SAT  = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } op_word_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               is_equal;
    logic [1:0]         fault;
  } res_word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_eq;
    logic [1:0]         fault;
    logic               den_zero;
    logic               neg_re;
    logic               neg_im;
    logic               ovf_re;
    logic               ovf_im;
    logic [63:0]        mag_re;
    logic [63:0]        mag_im;
    logic [63:0]        den;
    logic [63:0]        rem_re;
    logic [63:0]        rem_im;
    logic [QBITS-1:0]   q_re;
    logic [QBITS-1:0]   q_im;
  } step_t;

endpackage
`default_nettype wire

// ===== hdl/cna_front.sv =====
`default_nettype none
module cna_front import cna_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] tol,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire op_word_t    up,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output step_t            dn
);

  localparam int R0_SHIFT = QBITS - FRAC_BITS;

  function automatic logic [32:0] sat65(input logic signed [64:0] x);
    if (x > 65'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (x < -65'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, x[31:0]};
  endfunction

  // stage a: products
  logic               a_v;
  logic [2:0]         a_kind;
  logic signed [31:0] a_ar, a_ai, a_br, a_bi;
  logic signed [63:0] a_rr, a_ii, a_ri, a_ir, a_s1, a_s2;
  // stage b: sums
  logic               b_v;
  logic [2:0]         b_kind;
  logic signed [64:0] b_num_re, b_num_im;
  logic [63:0]        b_sq;
  logic signed [32:0] b_lin_re, b_lin_im;
  // stage c: magnitudes, simple results
  logic               c_v;
  logic [2:0]         c_kind;
  logic signed [31:0] c_res_re, c_res_im;
  logic               c_eq;
  logic [1:0]         c_fault;
  logic               c_neg_re, c_neg_im, c_zero;
  logic [63:0]        c_mag_re, c_mag_im, c_den;

  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic signed [31:0] sq1, sq2;
  logic signed [32:0] lin_re, lin_im;
  logic signed [64:0] mul_re, mul_im;
  logic [32:0] sat_re, sat_im;
  logic [32:0] abs_re, abs_im;
  logic [63:0] r0_re, r0_im;

  assign rdy_d = !dn_valid || dn_ready;
  assign rdy_c = !c_v || rdy_d;
  assign rdy_b = !b_v || rdy_c;
  assign rdy_a = !a_v || rdy_b;
  assign up_ready = rdy_a;

  assign sq1 = (up.kind == KIND_MOD) ? up.a_real : up.b_real;
  assign sq2 = (up.kind == KIND_MOD) ? up.a_imag : up.b_imag;

  always_comb begin
    case (a_kind)
      KIND_CONJ: begin
        lin_re = 33'(a_ar);
        lin_im = -33'(a_ai);
      end
      KIND_SUB, KIND_EQ: begin
        lin_re = 33'(a_ar) - 33'(a_br);
        lin_im = 33'(a_ai) - 33'(a_bi);
      end
      default: begin
        lin_re = 33'(a_ar) + 33'(a_br);
        lin_im = 33'(a_ai) + 33'(a_bi);
      end
    endcase
  end

  assign mul_re = b_num_re >>> FRAC_BITS;
  assign mul_im = b_num_im >>> FRAC_BITS;
  assign sat_re = (b_kind == KIND_MUL) ? sat65(mul_re) : sat65(65'(b_lin_re));
  assign sat_im = (b_kind == KIND_MUL) ? sat65(mul_im) : sat65(65'(b_lin_im));
  assign abs_re = b_lin_re[32] ? 33'(-b_lin_re) : 33'(b_lin_re);
  assign abs_im = b_lin_im[32] ? 33'(-b_lin_im) : 33'(b_lin_im);

  assign r0_re = c_mag_re >> R0_SHIFT;
  assign r0_im = c_mag_im >> R0_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy_a) a_v <= up_valid;
      if (rdy_b) b_v <= a_v;
      if (rdy_c) c_v <= b_v;
      if (rdy_d) dn_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      a_kind <= up.kind;
      a_ar <= up.a_real;
      a_ai <= up.a_imag;
      a_br <= up.b_real;
      a_bi <= up.b_imag;
      a_rr <= up.a_real * up.b_real;
      a_ii <= up.a_imag * up.b_imag;
      a_ri <= up.a_real * up.b_imag;
      a_ir <= up.a_imag * up.b_real;
      a_s1 <= sq1 * sq1;
      a_s2 <= sq2 * sq2;
    end
    if (rdy_b && a_v) begin
      b_kind <= a_kind;
      b_num_re <= (a_kind == KIND_DIV) ? 65'(a_rr) + 65'(a_ii) : 65'(a_rr) - 65'(a_ii);
      b_num_im <= (a_kind == KIND_DIV) ? 65'(a_ir) - 65'(a_ri) : 65'(a_ir) + 65'(a_ri);
      b_sq <= $unsigned(a_s1) + $unsigned(a_s2);
      b_lin_re <= lin_re;
      b_lin_im <= lin_im;
    end
    if (rdy_c && b_v) begin
      c_kind <= b_kind;
      c_neg_re <= b_num_re[64];
      c_neg_im <= b_num_im[64];
      c_mag_re <= b_num_re[64] ? 64'(-b_num_re) : 64'(b_num_re);
      c_mag_im <= b_num_im[64] ? 64'(-b_num_im) : 64'(b_num_im);
      c_den <= b_sq;
      c_zero <= (b_sq == 64'd0);
      c_res_re <= '0;
      c_res_im <= '0;
      c_eq <= 1'b0;
      c_fault <= FAULT_OK;
      case (b_kind)
        KIND_ADD, KIND_SUB, KIND_MUL, KIND_CONJ: begin
          c_res_re <= sat_re[31:0];
          c_res_im <= sat_im[31:0];
          c_fault <= (sat_re[32] || sat_im[32]) ? FAULT_SAT : FAULT_OK;
        end
        KIND_EQ: begin
          c_eq <= (abs_re <= {17'd0, tol}) && (abs_im <= {17'd0, tol});
        end
        default: begin
        end
      endcase
    end
    if (rdy_d && c_v) begin
      dn.kind <= c_kind;
      dn.res_re <= c_res_re;
      dn.res_im <= c_res_im;
      dn.is_eq <= c_eq;
      dn.fault <= c_fault;
      dn.den_zero <= c_zero;
      dn.neg_re <= c_neg_re;
      dn.neg_im <= c_neg_im;
      dn.ovf_re <= (r0_re >= c_den);
      dn.ovf_im <= (r0_im >= c_den);
      dn.mag_re <= c_mag_re;
      dn.mag_im <= c_mag_im;
      dn.den <= c_den;
      dn.rem_re <= (c_kind == KIND_MOD) ? 64'd0 : r0_re;
      dn.rem_im <= r0_im;
      dn.q_re <= '0;
      dn.q_im <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cna_step.sv =====
`default_nettype none
module cna_step import cna_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int BIT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire step_t up,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output step_t      dn
);

  localparam bit HAS_N = (BIT >= FRAC_BITS);
  localparam int NIDX = HAS_N ? BIT - FRAC_BITS : 0;
  localparam bit HAS_SQ = (BIT >= 1);
  localparam int SJ = HAS_SQ ? BIT - 1 : 0;

  step_t       nxt;
  logic        nb_re, nb_im;
  logic [64:0] t_re, t_im, dd;
  logic [35:0] st, trial;

  assign nb_re = HAS_N ? up.mag_re[NIDX] : 1'b0;
  assign nb_im = HAS_N ? up.mag_im[NIDX] : 1'b0;
  assign t_re = {up.rem_re, nb_re};
  assign t_im = {up.rem_im, nb_im};
  assign dd = {1'b0, up.den};
  assign st = {up.rem_re[33:0], up.den[2*SJ+1 -: 2]};
  assign trial = {2'b00, up.q_re[31:0], 2'b01};

  always_comb begin
    nxt = up;
    if (up.kind == KIND_DIV) begin
      if (t_re >= dd) begin
        nxt.rem_re = 64'(t_re - dd);
        nxt.q_re = {up.q_re[QBITS-2:0], 1'b1};
      end else begin
        nxt.rem_re = t_re[63:0];
        nxt.q_re = {up.q_re[QBITS-2:0], 1'b0};
      end
      if (t_im >= dd) begin
        nxt.rem_im = 64'(t_im - dd);
        nxt.q_im = {up.q_im[QBITS-2:0], 1'b1};
      end else begin
        nxt.rem_im = t_im[63:0];
        nxt.q_im = {up.q_im[QBITS-2:0], 1'b0};
      end
    end else if (up.kind == KIND_MOD && HAS_SQ) begin
      if (st >= trial) begin
        nxt.rem_re = {28'd0, st - trial};
        nxt.q_re = {up.q_re[QBITS-2:0], 1'b1};
      end else begin
        nxt.rem_re = {28'd0, st};
        nxt.q_re = {up.q_re[QBITS-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cna_back.sv =====
`default_nettype none
module cna_back import cna_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire step_t up,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output res_word_t  dn
);

  function automatic logic [32:0] div_sat(input logic neg, input logic ovf,
                                          input logic [QBITS-1:0] q);
    if (!neg) begin
      if (ovf || q > 33'h0_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, q[31:0]};
    end
    if (ovf || q > 33'h0_8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, 32'(~q[31:0] + 32'd1)};
  endfunction

  res_word_t   nxt;
  logic [32:0] d_re, d_im;

  assign d_re = div_sat(up.neg_re, up.ovf_re, up.q_re);
  assign d_im = div_sat(up.neg_im, up.ovf_im, up.q_im);

  always_comb begin
    nxt.result_real = up.res_re;
    nxt.result_imag = up.res_im;
    nxt.is_equal = up.is_eq;
    nxt.fault = up.fault;
    case (up.kind)
      KIND_DIV: begin
        if (up.den_zero) begin
          nxt.result_real = '0;
          nxt.result_imag = '0;
          nxt.fault = FAULT_DIV0;
        end else begin
          nxt.result_real = d_re[31:0];
          nxt.result_imag = d_im[31:0];
          nxt.fault = (d_re[32] || d_im[32]) ? FAULT_SAT : FAULT_OK;
        end
      end
      KIND_MOD: begin
        nxt.result_imag = '0;
        if (up.q_re[31]) begin
          nxt.result_real = 32'h7FFF_FFFF;
          nxt.fault = FAULT_SAT;
        end else begin
          nxt.result_real = up.q_re[31:0];
          nxt.fault = FAULT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/complex_number_alu_core.sv =====
// pipeline: an accepted op word passes 4 front stages, 33 divide/square-root bit
// stages and 1 output register on its way to res_valid
// throughput: one word per cycle while res_ready is high; each stage holds its word while stalled
// reset: synchronous, clears all valid bits and the equality tolerance
`default_nettype none
module complex_number_alu_core import cna_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        op_valid,
  output logic             op_ready,
  input  wire op_word_t    op,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_word_t        res
);

  logic [15:0] tol;
  logic        pv [0:QBITS];
  logic        pr [0:QBITS];
  step_t       pd [0:QBITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_we) begin
      tol <= cfg_data;
    end
  end

  cna_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .tol(tol),
    .up_valid(op_valid), .up_ready(op_ready), .up(op),
    .dn_valid(pv[0]), .dn_ready(pr[0]), .dn(pd[0])
  );

  for (genvar g = 0; g < QBITS; g++) begin : g_step
    cna_step #(.FRAC_BITS(FRAC_BITS), .BIT(QBITS - 1 - g)) u_step (
      .clk(clk), .rst(rst),
      .up_valid(pv[g]), .up_ready(pr[g]), .up(pd[g]),
      .dn_valid(pv[g+1]), .dn_ready(pr[g+1]), .dn(pd[g+1])
    );
  end

  cna_back u_back (
    .clk(clk), .rst(rst),
    .up_valid(pv[QBITS]), .up_ready(pr[QBITS]), .up(pd[QBITS]),
    .dn_valid(res_valid), .dn_ready(res_ready), .dn(res)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> res_valid)
    else $error("input stalled with no result waiting");

  a_eq_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_equal |->
      res.fault == FAULT_OK && res.result_real == 0 && res.result_imag == 0)
    else $error("equal word carries data or fault");

  a_div0_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.fault == FAULT_DIV0 |->
      res.result_real == 0 && res.result_imag == 0 && !res.is_equal)
    else $error("divide by zero word not cleared");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import cna_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic op_valid = 1'b0;
  logic op_ready;
  op_word_t op = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_word_t res;

  complex_number_alu_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .op_valid(op_valid), .op_ready(op_ready), .op(op),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int FB = 16;
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MAXN = 32'h8000_0000;

  res_word_t alu_results_q[$];
  logic [15:0] tol;
  int errors = 0;
  logic calm = 1'b0;
  logic hold_long = 1'b0;
  logic stim_done = 1'b0;

  function automatic logic [31:0] clamp_mag(input logic neg, input logic [63:0] mag,
                                            inout logic [1:0] f);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        f = FAULT_SAT;
        return MAXP;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      f = FAULT_SAT;
      return MAXN;
    end
    return 32'd0 - mag[31:0];
  endfunction

  function automatic logic [31:0] clamp_s(input logic signed [63:0] s, inout logic [1:0] f);
    if (s < 0) return clamp_mag(1'b1, 64'd0 - s, f);
    return clamp_mag(1'b0, s, f);
  endfunction

  function automatic logic [63:0] sign_mag(input logic signed [63:0] p,
                                           input logic signed [63:0] q, output logic neg);
    logic [63:0] u;
    u = p + q;
    neg = u[63] && (u != 64'h8000_0000_0000_0000);
    return neg ? 64'd0 - u : u;
  endfunction

  function automatic logic [31:0] prod_part(input logic signed [63:0] p,
                                            input logic signed [63:0] q, inout logic [1:0] f);
    logic neg;
    logic [63:0] m;
    m = sign_mag(p, q, neg);
    if (neg) return clamp_mag(1'b1, (m + 64'hFFFF) >> FB, f);
    return clamp_mag(1'b0, m >> FB, f);
  endfunction

  function automatic logic [31:0] quot_part(input logic signed [63:0] p,
                                            input logic signed [63:0] q,
                                            input logic [63:0] den, inout logic [1:0] f);
    logic neg;
    logic [63:0] m, quo, rem;
    m = sign_mag(p, q, neg);
    quo = m / den;
    rem = m % den;
    for (int i = 0; i < FB; i++) begin
      if (quo > (64'd1 << 40)) begin
        quo = '1;
        break;
      end
      quo = quo << 1;
      rem = rem << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return clamp_mag(neg, quo, f);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic res_word_t alu_predict(input op_word_t w);
    res_word_t r;
    logic signed [63:0] ar, ai, br, bi, dr, di;
    logic [63:0] den;
    logic [1:0] f;
    ar = w.a_real; ai = w.a_imag; br = w.b_real; bi = w.b_imag;
    r = '0;
    f = FAULT_OK;
    case (w.kind)
      KIND_ADD: begin
        r.result_real = clamp_s(ar + br, f);
        r.result_imag = clamp_s(ai + bi, f);
      end
      KIND_SUB: begin
        r.result_real = clamp_s(ar - br, f);
        r.result_imag = clamp_s(ai - bi, f);
      end
      KIND_MUL: begin
        r.result_real = prod_part(ar * br, -(ai * bi), f);
        r.result_imag = prod_part(ar * bi, ai * br, f);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          f = FAULT_DIV0;
        end else begin
          r.result_real = quot_part(ar * br, ai * bi, den, f);
          r.result_imag = quot_part(ai * br, -(ar * bi), den, f);
        end
      end
      KIND_CONJ: begin
        r.result_real = w.a_real;
        r.result_imag = clamp_s(-ai, f);
      end
      KIND_MOD: r.result_real = clamp_mag(1'b0, int_sqrt(ar * ar + ai * ai), f);
      KIND_EQ: begin
        dr = ar - br;
        di = ai - bi;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        r.is_equal = (dr <= tol) && (di <= tol);
      end
      default: ;
    endcase
    r.fault = f;
    return r;
  endfunction

  function automatic logic [31:0] rnd_part();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MAXP - $urandom_range(0, 3) : MAXN + $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? 32'd0 : 32'h0001_0000;
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
    endcase
  endfunction

  function automatic op_word_t rnd_word();
    op_word_t w;
    w.kind = 3'($urandom_range(0, 7));
    w.a_real = rnd_part();
    w.a_imag = rnd_part();
    w.b_real = rnd_part();
    w.b_imag = ($urandom_range(0, 7) == 0) ? 32'd0 : rnd_part();
    if (w.kind == KIND_EQ && $urandom_range(0, 1)) begin
      w.b_real = w.a_real + $signed(32'($urandom_range(0, 8))) - 4;
      w.b_imag = w.a_imag - $signed(32'($urandom_range(0, 3)));
    end
    return w;
  endfunction

  task automatic send_word(input op_word_t w, input logic chk, input res_word_t exp_r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      op_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    op <= w;
    op_valid <= 1'b1;
    alu_results_q.push_back(chk ? exp_r : alu_predict(w));
    @(posedge clk);
    while (!op_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_set(input logic [15:0] v);
    op_valid <= 1'b0;
    while (alu_results_q.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    tol = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  typedef struct {
    op_word_t w;
    logic chk;
    res_word_t r;
  } row_t;

  row_t rows[$];

  initial begin
    tol = 16'd0;
    rows = '{
      '{'{KIND_ADD, MAXP, MAXN, 32'sd1, -32'sd1}, 1'b1, '{MAXP, MAXN, 1'b0, FAULT_SAT}},
      '{'{KIND_ADD, 32'sd5, 32'sd6, 32'sd7, 32'sd8}, 1'b1, '{32'sd12, 32'sd14, 1'b0, FAULT_OK}},
      '{'{KIND_SUB, MAXN, MAXP, 32'sd1, -32'sd1}, 1'b1, '{MAXN, MAXP, 1'b0, FAULT_SAT}},
      '{'{KIND_MUL, MAXP, MAXP, MAXP, MAXN}, 1'b0, '0},
      '{'{KIND_MUL, MAXN, 32'sd0, MAXN, 32'sd0}, 1'b0, '0},
      '{'{KIND_MUL, -32'sd1, 32'sd3, 32'sd1, -32'sd7}, 1'b0, '0},
      '{'{KIND_DIV, 32'sd5, 32'sd5, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0, FAULT_DIV0}},
      '{'{KIND_DIV, MAXP, MAXN, 32'sd1, 32'sd0}, 1'b0, '0},
      '{'{KIND_DIV, 32'sh30000, -32'sh10000, 32'sh20000, 32'sd0}, 1'b0, '0},
      '{'{KIND_DIV, MAXN, MAXN, MAXN, MAXN}, 1'b0, '0},
      '{'{KIND_CONJ, MAXN, MAXN, 32'sd0, 32'sd0}, 1'b1, '{MAXN, MAXP, 1'b0, FAULT_SAT}},
      '{'{KIND_CONJ, MAXP, MAXP, 32'sd0, 32'sd0}, 1'b1, '{MAXP, MAXN + 1, 1'b0, FAULT_OK}},
      '{'{KIND_MOD, MAXN, MAXN, 32'sd0, 32'sd0}, 1'b0, '0},
      '{'{KIND_MOD, 32'sd3, 32'sd4, 32'sd0, 32'sd0}, 1'b1, '{32'sd5, 32'sd0, 1'b0, FAULT_OK}},
      '{'{KIND_MOD, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '0},
      '{'{KIND_EQ, MAXP, MAXN, MAXP, MAXN}, 1'b1, '{32'sd0, 32'sd0, 1'b1, FAULT_OK}},
      '{'{KIND_EQ, MAXP, MAXN, MAXN, MAXP}, 1'b1, '0},
      '{'{KIND_EQ, 32'sd1, 32'sd1, 32'sd2, 32'sd1}, 1'b1, '0},
      '{'{3'd7, MAXP, MAXN, -32'sd1, 32'sd1}, 1'b1, '0}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_word(rows[i].w, rows[i].chk, rows[i].r);
    drain_and_set(16'hFFFF);
    send_word('{KIND_EQ, 32'sd0, MAXN, 32'sh0000_FFFF, MAXN + 32'sh0000_FFFF}, 1'b1,
              '{32'sd0, 32'sd0, 1'b1, FAULT_OK});
    send_word('{KIND_EQ, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sd0}, 1'b1, '0);
    for (int i = 0; i < 250; i++) send_word(rnd_word(), 1'b0, '0);
    drain_and_set(16'd3);
    // fill the pipeline while the output is held
    hold_long = 1'b1;
    for (int i = 0; i < 250; i++) send_word(rnd_word(), 1'b0, '0);
    drain_and_set(16'd0);
    for (int i = 0; i < 200; i++) send_word(rnd_word(), 1'b0, '0);
    calm = 1'b1;
    for (int i = 0; i < 100; i++) send_word(rnd_word(), 1'b0, '0);
    op_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    logic held;
    held = 1'b0;
    @(negedge clk);
    while (1) begin
      if (hold_long && !held) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (200) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 7) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      res_ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_word_t e;
    if (!rst && res_valid && res_ready) begin
      if (alu_results_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, res);
        errors++;
      end else begin
        e = alu_results_q.pop_front();
        if (res.result_real !== e.result_real || res.result_imag !== e.result_imag ||
            res.is_equal !== e.is_equal || res.fault !== e.fault) begin
          $display("%0t: expected re %h im %h eq %b f %0d, actual re %h im %h eq %b f %0d",
                   $time, e.result_real, e.result_imag, e.is_equal, e.fault,
                   res.result_real, res.result_imag, res.is_equal, res.fault);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (alu_results_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
